>>> hdl/mexp_pkg.sv
`default_nettype none
package mexp_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int PC_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_WAIT   = 3'd0;
  localparam pc_t PC_CHECK  = 3'd1;
  localparam pc_t PC_REDUCE = 3'd2;
  localparam pc_t PC_TEST   = 3'd3;
  localparam pc_t PC_MUL    = 3'd4;
  localparam pc_t PC_SQR    = 3'd5;
  localparam pc_t PC_NEXT   = 3'd6;
  localparam pc_t PC_EMIT   = 3'd7;

  typedef enum logic [1:0] {
    SEL_REDUCE,
    SEL_ACC,
    SEL_SQR
  } sel_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_BAD,
    COND_EBIT_ZERO,
    COND_MORE_BITS,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic  accept;
    logic  mul;
    sel_t  mul_sel;
    logic  shift;
    logic  emit;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic bad;
    logic ebit_zero;
    logic more_bits;
    logic out_busy;
    logic mul_done;
  } mexp_stat_t;

  typedef struct packed {
    logic ready;
    logic mul_start;
    sel_t mul_sel;
    logic shift;
    logic emit;
  } mexp_ctrl_t;

  // Control store. The loop from PC_TEST to PC_NEXT runs once per exponent bit.
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{accept: 1'b0, mul: 1'b0, mul_sel: SEL_REDUCE, shift: 1'b0, emit: 1'b0,
          cond: COND_NEVER, target: PC_WAIT};
    unique case (pc)
      PC_WAIT: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = PC_WAIT;
      end
      PC_CHECK: begin
        w.cond   = COND_BAD;
        w.target = PC_EMIT;
      end
      PC_REDUCE: begin
        w.mul     = 1'b1;
        w.mul_sel = SEL_REDUCE;
      end
      PC_TEST: begin
        w.cond   = COND_EBIT_ZERO;
        w.target = PC_SQR;
      end
      PC_MUL: begin
        w.mul     = 1'b1;
        w.mul_sel = SEL_ACC;
      end
      PC_SQR: begin
        w.mul     = 1'b1;
        w.mul_sel = SEL_SQR;
      end
      PC_NEXT: begin
        w.shift  = 1'b1;
        w.cond   = COND_MORE_BITS;
        w.target = PC_TEST;
      end
      PC_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = PC_EMIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = PC_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> hdl/mexp_mulmod.sv
`default_nettype none
module mexp_mulmod #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic [W-1:0] m,
  output logic              done,
  output logic [W-1:0]      result
);
  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W+1:0]  t;
  logic [W+2:0]  d1, d2;
  logic [W-1:0]  r_step;

  // One multiplier bit per cycle, MSB first: r = (2r + bit*b) mod m.
  // With r < m and b <= m the sum stays below 3m.
  always_comb begin
    t  = {1'b0, r_r, 1'b0} + (a_r[W-1] ? {2'b00, b} : '0);
    d1 = {1'b0, t} - {3'b000, m};
    d2 = {1'b0, t} - {2'b00, m, 1'b0};
    if (!d2[W+2]) begin
      r_step = d2[W-1:0];
    end else if (!d1[W+2]) begin
      r_step = d1[W-1:0];
    end else begin
      r_step = t[W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    r_nxt    = r_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      a_nxt    = a;
      r_nxt    = '0;
    end else if (busy_r) begin
      r_nxt   = r_step;
      a_nxt   = {a_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r <= a_nxt;
    r_r <= r_nxt;
  end

  assign done   = done_r;
  assign result = r_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r && !done_r)
    else $error("multiplier started while an operation was in flight");
  a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> done_r)
    else $error("multiplier went idle without signaling completion");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("completion without a running operation");

endmodule
`default_nettype wire

>>> hdl/mexp_seq.sv
`default_nettype none
module mexp_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mexp_pkg::mexp_stat_t  stat,
  output mexp_pkg::mexp_ctrl_t       ctrl
);
  import mexp_pkg::*;

  pc_t    pc_r, pc_nxt;
  logic   issued_r, issued_nxt;
  uword_t w;
  logic   take;
  logic   advance;

  always_comb begin
    w = ucode(pc_r);
    case (w.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_INPUT:  take = !stat.in_valid;
      COND_BAD:       take = stat.bad;
      COND_EBIT_ZERO: take = stat.ebit_zero;
      COND_MORE_BITS: take = stat.more_bits;
      COND_OUT_BUSY:  take = stat.out_busy;
      default:        take = 1'b0;
    endcase
    advance = !w.mul || stat.mul_done;

    if (take) begin
      pc_nxt = w.target;
    end else if (advance) begin
      pc_nxt = pc_r + 1'b1;
    end else begin
      pc_nxt = pc_r;
    end

    ctrl.ready     = w.accept;
    ctrl.mul_start = w.mul && !issued_r;
    ctrl.mul_sel   = w.mul_sel;
    ctrl.shift     = w.shift;
    ctrl.emit      = w.emit && !stat.out_busy;

    if (ctrl.mul_start) begin
      issued_nxt = 1'b1;
    end else if (stat.mul_done) begin
      issued_nxt = 1'b0;
    end else begin
      issued_nxt = issued_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= PC_WAIT;
      issued_r <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      issued_r <= issued_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/modular_exponentiation.sv
`default_nettype none
// Each transaction runs on the shared modular multiplier: one product to reduce the message,
// one square per exponent bit and one more product per set bit; a zero modulus skips them all.
// One transaction is in flight; the next is taken while a result waits at the output.
// Reset (rst_n low, synchronous) sets modulus and exponent to 1 and empties the block.
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mexp_pkg::DATA_W-1:0]     cfg_wdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [mexp_pkg::DATA_W-1:0]     in_tdata,   // [31:0] message
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [mexp_pkg::DATA_W-1:0]          out_tdata,  // [31:0] power
  output logic                                 out_tuser   // [0] bad_modulus
);
  import mexp_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [DATA_W-1:0] modulus_r, exponent_r;
  logic [W-1:0]      base_r, acc_r, exp_r;
  logic [CW-1:0]     bit_cnt_r;
  logic              bad_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_power_r;
  logic              out_bad_r;

  mexp_stat_t stat;
  mexp_ctrl_t ctrl;

  logic [W-1:0] m_w;
  logic         bad_w;
  logic         accept;
  logic         out_busy;
  logic [W-1:0] mul_a, mul_b, mul_res;
  logic         mul_done;

  assign m_w      = modulus_r[W-1:0];
  assign bad_w    = (m_w == '0);
  assign accept   = in_tvalid && ctrl.ready;
  assign out_busy = out_valid_r && !out_tready;

  always_comb begin
    stat.in_valid  = in_tvalid;
    stat.bad       = bad_r;
    stat.ebit_zero = !exp_r[0];
    stat.more_bits = (bit_cnt_r != CW'(1));
    stat.out_busy  = out_busy;
    stat.mul_done  = mul_done;
  end

  always_comb begin
    case (ctrl.mul_sel)
      SEL_ACC: begin
        mul_a = acc_r;
        mul_b = base_r;
      end
      SEL_SQR: begin
        mul_a = base_r;
        mul_b = base_r;
      end
      default: begin
        mul_a = base_r;
        mul_b = W'(1);
      end
    endcase
  end

  mexp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  mexp_mulmod #(.W(W)) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctrl.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (m_w),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= DATA_W'(1);
      exponent_r <= DATA_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:  modulus_r  <= cfg_wdata;
        REG_EXPONENT: exponent_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base_r    <= in_tdata[W-1:0];
      acc_r     <= bad_w ? '0 : W'(1);
      exp_r     <= exponent_r[W-1:0];
      bit_cnt_r <= CW'(W);
      bad_r     <= bad_w;
    end else begin
      if (mul_done) begin
        case (ctrl.mul_sel) inside
          SEL_REDUCE, SEL_SQR: base_r <= mul_res;
          default:             acc_r  <= mul_res;
        endcase
      end
      if (ctrl.shift) begin
        exp_r     <= exp_r >> 1;
        bit_cnt_r <= bit_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (ctrl.emit) begin
      out_power_r <= DATA_W'(acc_r);
      out_bad_r   <= bad_r;
    end
  end

  assign in_tready  = ctrl.ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_power_r;
  assign out_tuser  = out_bad_r;

endmodule
`default_nettype wire
